### rtl/rfpt_pkg.sv
// ---------------------------------------------------------------------------
// rfpt_pkg
// Shared types, constants and the square-root level table of the RF power
// tick controller.
// ---------------------------------------------------------------------------
`default_nettype none

package rfpt_pkg;

  // default tuning of the controller
  localparam int PULSE_PERIOD_DEF = 100;
  localparam int PULSE_ON_DEF     = 20;
  localparam int KNOB_MAX_DEF     = 127;
  localparam int SLEW_STEP_DEF    = 20;
  localparam int FAULT_HOLD_DEF   = 512;
  localparam int BLINK_TOP_DEF    = 512;

  localparam int LEVEL_W = 9;
  localparam int KNOB_W  = 7;
  localparam int TEMP_W  = 10;
  localparam int SUM_W   = 18;
  localparam int AVG_W   = 8;
  localparam int HOLD_W  = 10;
  localparam int BLINK_W = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [LEVEL_W-1:0] LEVEL_CAP        = 9'd256;
  localparam logic [LEVEL_W-1:0] PWM_TOP          = 9'h100;
  localparam logic [TEMP_W-1:0]  TEMP_LIMIT_RESET = 10'd431;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REMOTE_MODE       = 3'd0,
    REG_REMOTE_LEVEL      = 3'd1,
    REG_REMOTE_PULSE_MODE = 3'd2,
    REG_REMOTE_CH1_ON     = 3'd3,
    REG_REMOTE_CH2_ON     = 3'd4,
    REG_TEMP_LIMIT        = 3'd5
  } rfpt_reg_e;

  typedef struct packed {
    logic               remote_mode;
    logic [LEVEL_W-1:0] remote_level;
    logic               remote_pulse_mode;
    logic               remote_channel1_on;
    logic               remote_channel2_on;
    logic [TEMP_W-1:0]  temp_limit;
  } rfpt_cfg_t;

  typedef struct packed {
    logic              knob_a;
    logic              knob_b;
    logic              fault_in_1;
    logic              fault_in_2;
    logic [TEMP_W-1:0] temp_sample_1;
    logic [TEMP_W-1:0] temp_sample_2;
    logic              continuous_pin;
    logic              single_pin;
  } rfpt_item_t;

  // status from the health monitor for the tick being processed
  typedef struct packed {
    logic hold_any_old;  // either hold running before this tick
    logic hold_1;
    logic hold_2;
    logic hot_1;
    logic hot_2;
    logic pulse_gate;    // pulse timer inside its on window
  } rfpt_health_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] pwm_value;
    logic               power_led_n;
    logic               overtemp_led_1_n;
    logic               overtemp_led_2_n;
    logic               fault_led_1_n;
    logic               fault_led_2_n;
    logic               remote_led_n;
    logic               rf_on;
    logic               enable_1;
    logic               enable_2;
  } rfpt_result_t;

  // piecewise-linear square root, 8 segments, slopes in 3.16
  localparam logic [KNOB_W-1:0] SEG_TOP [8] = '{
    7'd16, 7'd32, 7'd48, 7'd64, 7'd80, 7'd96, 7'd112, 7'd127
  };
  localparam logic [18:0] SEG_SLOPE [8] = '{
    19'd372184, 19'd154164, 19'd118294, 19'd99726,
    19'd87861, 19'd79432, 19'd73045, 19'd68127
  };
  localparam logic [6:0] SEG_BASE [8] = '{
    7'd0, 7'd53, 7'd71, 7'd84, 7'd96, 7'd106, 7'd116, 7'd124
  };

  function automatic logic [LEVEL_W-1:0] sqrt_level(logic [KNOB_W-1:0] pos);
    logic [2:0]  seg;
    logic [25:0] prod;
    seg = 3'd7;
    // first segment whose top covers the position
    for (int k = 7; k >= 0; k--) begin
      if (pos <= SEG_TOP[k]) seg = 3'(k);
    end
    prod = 26'(pos) * 26'(SEG_SLOPE[seg]);
    return {1'b0, prod[23:16]} + 9'(SEG_BASE[seg]);
  endfunction

endpackage

`default_nettype wire

### rtl/rf_power_tick_controller.sv
// A tick transferred in waits in the input register, then loads into the result
// register once that is empty or its result is taken, and leaves from there.
// Throughput: one tick per cycle unless stalled; one registered pass per step.
// A stalled result register holds one finished tick while one more waits.
// Reset clears all tick state and loads temp_limit with 431, other regs 0.
// ---------------------------------------------------------------------------
// rf_power_tick_controller
// Per-tick RF power control: knob level, slew limiting, LEDs and enables.
// ---------------------------------------------------------------------------
`default_nettype none

module rf_power_tick_controller import rfpt_pkg::*; #(
  parameter int PULSE_PERIOD = PULSE_PERIOD_DEF,
  parameter int PULSE_ON     = PULSE_ON_DEF,
  parameter int KNOB_MAX     = KNOB_MAX_DEF,
  parameter int SLEW_STEP    = SLEW_STEP_DEF,
  parameter int FAULT_HOLD   = FAULT_HOLD_DEF,
  parameter int BLINK_TOP    = BLINK_TOP_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  knob_a_i,
  input  wire logic                  knob_b_i,
  input  wire logic                  fault_in_1_i,
  input  wire logic                  fault_in_2_i,
  input  wire logic [TEMP_W-1:0]     temp_sample_1_i,
  input  wire logic [TEMP_W-1:0]     temp_sample_2_i,
  input  wire logic                  continuous_pin_i,
  input  wire logic                  single_pin_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [LEVEL_W-1:0]         pwm_value_o,
  output logic                       power_led_n_o,
  output logic                       overtemp_led_1_n_o,
  output logic                       overtemp_led_2_n_o,
  output logic                       fault_led_1_n_o,
  output logic                       fault_led_2_n_o,
  output logic                       remote_led_n_o,
  output logic                       rf_on_o,
  output logic                       enable_1_o,
  output logic                       enable_2_o
);

  localparam logic [BLINK_W-1:0] BLINK_LAST = BLINK_W'(BLINK_TOP);
  localparam logic [LEVEL_W:0]   STEP       = (LEVEL_W + 1)'(SLEW_STEP);

  rfpt_cfg_t          cfg_q;
  rfpt_item_t         item_q;
  logic               item_valid_q;
  rfpt_result_t       res_q, res_d;
  logic               out_valid_q;
  logic               adv;
  logic [LEVEL_W-1:0] level;
  rfpt_health_t       health;
  logic [BLINK_W-1:0] blink_q, blink_d;
  logic [LEVEL_W-1:0] slew_q, slew_d, level_eff;
  logic [LEVEL_W:0]   slew_up;
  logic               power_on, rf, en_1, en_2;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.remote_mode        <= 1'b0;
      cfg_q.remote_level       <= '0;
      cfg_q.remote_pulse_mode  <= 1'b0;
      cfg_q.remote_channel1_on <= 1'b0;
      cfg_q.remote_channel2_on <= 1'b0;
      cfg_q.temp_limit         <= TEMP_LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_REMOTE_MODE:       cfg_q.remote_mode        <= cfg_wdata_i[0];
        REG_REMOTE_LEVEL:      cfg_q.remote_level       <= cfg_wdata_i[LEVEL_W-1:0];
        REG_REMOTE_PULSE_MODE: cfg_q.remote_pulse_mode  <= cfg_wdata_i[0];
        REG_REMOTE_CH1_ON:     cfg_q.remote_channel1_on <= cfg_wdata_i[0];
        REG_REMOTE_CH2_ON:     cfg_q.remote_channel2_on <= cfg_wdata_i[0];
        REG_TEMP_LIMIT:        cfg_q.temp_limit         <= cfg_wdata_i[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // tick moves from the input register into the result register
  assign adv        = item_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = item_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.knob_a         <= knob_a_i;
      item_q.knob_b         <= knob_b_i;
      item_q.fault_in_1     <= fault_in_1_i;
      item_q.fault_in_2     <= fault_in_2_i;
      item_q.temp_sample_1  <= temp_sample_1_i;
      item_q.temp_sample_2  <= temp_sample_2_i;
      item_q.continuous_pin <= continuous_pin_i;
      item_q.single_pin     <= single_pin_i;
    end
  end

  rfpt_knob #(
    .KNOB_MAX (KNOB_MAX)
  ) u_knob (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .knob_a_i (item_q.knob_a),
    .knob_b_i (item_q.knob_b),
    .cfg_i    (cfg_q),
    .level_o  (level)
  );

  rfpt_health #(
    .PULSE_PERIOD (PULSE_PERIOD),
    .PULSE_ON     (PULSE_ON),
    .FAULT_HOLD   (FAULT_HOLD)
  ) u_health (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .health_o (health)
  );

  always_comb begin
    blink_d  = (blink_q >= BLINK_LAST) ? '0 : blink_q + 1'b1;
    power_on = blink_d < {level, 1'b0};

    level_eff = health.hold_any_old ? '0 : level;
    slew_up   = {1'b0, slew_q} + STEP;
    if (level_eff < slew_q) begin
      slew_d = level_eff;
    end else if ({1'b0, level_eff} >= slew_up) begin
      slew_d = slew_up[LEVEL_W-1:0];
    end else begin
      slew_d = level_eff;
    end

    if (cfg_q.remote_mode) begin
      rf   = !cfg_q.remote_pulse_mode || health.pulse_gate;
      en_1 = !health.hold_1 && !health.hot_1 && cfg_q.remote_channel1_on;
      en_2 = !health.hold_2 && !health.hot_2 && cfg_q.remote_channel2_on;
    end else begin
      rf   = item_q.continuous_pin || health.pulse_gate;
      en_1 = !health.hold_1 && !health.hot_1;
      en_2 = !health.hold_2 && !health.hot_2 && !item_q.single_pin;
    end

    res_d.pwm_value        = PWM_TOP - slew_d;
    res_d.power_led_n      = !power_on;
    res_d.overtemp_led_1_n = !health.hot_1;
    res_d.overtemp_led_2_n = !health.hot_2;
    res_d.fault_led_1_n    = !health.hold_1;
    res_d.fault_led_2_n    = !health.hold_2;
    res_d.remote_led_n     = !cfg_q.remote_mode;
    res_d.rf_on            = rf;
    res_d.enable_1         = en_1;
    res_d.enable_2         = en_2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_q     <= '0;
      slew_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        blink_q <= blink_d;
        slew_q  <= slew_d;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign pwm_value_o        = res_q.pwm_value;
  assign power_led_n_o      = res_q.power_led_n;
  assign overtemp_led_1_n_o = res_q.overtemp_led_1_n;
  assign overtemp_led_2_n_o = res_q.overtemp_led_2_n;
  assign fault_led_1_n_o    = res_q.fault_led_1_n;
  assign fault_led_2_n_o    = res_q.fault_led_2_n;
  assign remote_led_n_o     = res_q.remote_led_n;
  assign rf_on_o            = res_q.rf_on;
  assign enable_1_o         = res_q.enable_1;
  assign enable_2_o         = res_q.enable_2;

  // a fault pin seen on a transfer shows on the next result
  a_fault_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && item_q.fault_in_1 |=> out_valid_o && !fault_led_1_n_o)
    else $error("fault hold not reported");

  // the slewed level never rises by more than one step per tick
  a_slew_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> {1'b0, slew_q} <= {1'b0, $past(slew_q)} + STEP)
    else $error("slew step exceeded");

  // a tick waiting in the input register is never dropped
  a_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q && !adv |=> item_valid_q)
    else $error("pending tick lost");

endmodule

`default_nettype wire

### rtl/rfpt_knob.sv
// ---------------------------------------------------------------------------
// rfpt_knob
// Quadrature knob decoder with saturating position and level selection
// (square-root table in local mode, register in remote mode).
// ---------------------------------------------------------------------------
`default_nettype none

module rfpt_knob import rfpt_pkg::*; #(
  parameter int KNOB_MAX = KNOB_MAX_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire logic               knob_a_i,
  input  wire logic               knob_b_i,
  input  wire rfpt_cfg_t          cfg_i,
  output logic [LEVEL_W-1:0]      level_o
);

  localparam logic [KNOB_W-1:0] POS_MAX = KNOB_W'(KNOB_MAX);

  logic              prev_a_q, prev_b_q;
  logic [KNOB_W-1:0] pos_q, pos_d;
  logic              step_up, step_dn;
  logic [LEVEL_W-1:0] raw_level;

  always_comb begin
    step_up = 1'b0;
    step_dn = 1'b0;
    // first matching edge wins: A rise, A fall, B rise, B fall
    if (knob_a_i && !prev_a_q) begin
      step_dn = knob_b_i;
      step_up = !knob_b_i;
    end else if (!knob_a_i && prev_a_q) begin
      step_up = knob_b_i;
      step_dn = !knob_b_i;
    end else if (knob_b_i && !prev_b_q) begin
      step_up = knob_a_i;
      step_dn = !knob_a_i;
    end else if (!knob_b_i && prev_b_q) begin
      step_dn = knob_a_i;
      step_up = !knob_a_i;
    end

    pos_d = pos_q;
    if (step_up && pos_q < POS_MAX) begin
      pos_d = pos_q + 1'b1;
    end else if (step_dn && pos_q != '0) begin
      pos_d = pos_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_a_q <= 1'b0;
      prev_b_q <= 1'b0;
      pos_q    <= '0;
    end else if (adv_i && !cfg_i.remote_mode) begin
      prev_a_q <= knob_a_i;
      prev_b_q <= knob_b_i;
      pos_q    <= pos_d;
    end
  end

  always_comb begin
    raw_level = cfg_i.remote_mode ? cfg_i.remote_level : sqrt_level(pos_d);
    level_o   = (raw_level > LEVEL_CAP) ? LEVEL_CAP : raw_level;
  end

endmodule

`default_nettype wire

### rtl/rfpt_health.sv
// ---------------------------------------------------------------------------
// rfpt_health
// Temperature averaging, fault hold timers and the pulse timer.
// ---------------------------------------------------------------------------
`default_nettype none

module rfpt_health import rfpt_pkg::*; #(
  parameter int PULSE_PERIOD = PULSE_PERIOD_DEF,
  parameter int PULSE_ON     = PULSE_ON_DEF,
  parameter int FAULT_HOLD   = FAULT_HOLD_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         adv_i,
  input  wire rfpt_item_t   item_i,
  input  wire rfpt_cfg_t    cfg_i,
  output rfpt_health_t      health_o
);

  localparam int PULSE_W = $clog2(PULSE_PERIOD + 1);
  localparam logic [PULSE_W-1:0] PULSE_TOP = PULSE_W'(PULSE_PERIOD);
  localparam logic [HOLD_W-1:0]  HOLD_LOAD = HOLD_W'(FAULT_HOLD);

  logic [SUM_W-1:0]   sum_1_q, sum_1_d, sum_2_q, sum_2_d;
  logic [SUM_W-1:0]   acc_1, acc_2;
  logic [AVG_W-1:0]   avg_q, avg_d;
  logic               ot_1_q, ot_1_d, ot_2_q, ot_2_d;
  logic [HOLD_W-1:0]  hold_1_q, hold_1_d, hold_2_q, hold_2_d;
  logic [PULSE_W-1:0] pulse_q, pulse_d;

  always_comb begin
    acc_1 = sum_1_q + SUM_W'(item_i.temp_sample_1);
    acc_2 = sum_2_q + SUM_W'(item_i.temp_sample_2);
    avg_d = avg_q + 1'b1;
    sum_1_d = acc_1;
    sum_2_d = acc_2;
    ot_1_d  = ot_1_q;
    ot_2_d  = ot_2_q;
    // window of 256 ticks closes when the counter wraps
    if (avg_d == '0) begin
      ot_1_d  = acc_1[SUM_W-1:8] < cfg_i.temp_limit;
      ot_2_d  = acc_2[SUM_W-1:8] < cfg_i.temp_limit;
      sum_1_d = '0;
      sum_2_d = '0;
    end

    if (item_i.fault_in_1)   hold_1_d = HOLD_LOAD;
    else if (hold_1_q != '0) hold_1_d = hold_1_q - 1'b1;
    else                     hold_1_d = hold_1_q;
    if (item_i.fault_in_2)   hold_2_d = HOLD_LOAD;
    else if (hold_2_q != '0) hold_2_d = hold_2_q - 1'b1;
    else                     hold_2_d = hold_2_q;

    pulse_d = (pulse_q < PULSE_TOP) ? pulse_q + 1'b1 : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_1_q  <= '0;
      sum_2_q  <= '0;
      avg_q    <= '0;
      ot_1_q   <= 1'b0;
      ot_2_q   <= 1'b0;
      hold_1_q <= '0;
      hold_2_q <= '0;
      pulse_q  <= '0;
    end else if (adv_i) begin
      sum_1_q  <= sum_1_d;
      sum_2_q  <= sum_2_d;
      avg_q    <= avg_d;
      ot_1_q   <= ot_1_d;
      ot_2_q   <= ot_2_d;
      hold_1_q <= hold_1_d;
      hold_2_q <= hold_2_d;
      pulse_q  <= pulse_d;
    end
  end

  always_comb begin
    health_o.hold_any_old = (hold_1_q != '0) || (hold_2_q != '0);
    health_o.hold_1       = hold_1_d != '0;
    health_o.hold_2       = hold_2_d != '0;
    health_o.hot_1        = ot_1_d;
    health_o.hot_2        = ot_2_d;
    // an on window longer than the period keeps the gate open
    health_o.pulse_gate   = (PULSE_ON > PULSE_PERIOD) ||
                            (pulse_d < PULSE_W'(PULSE_ON));
  end

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the RF power tick controller. Ticks come from a
// queue and go through a valid/stall driver with random gaps. A predictor
// runs in step with every accepted tick, and a monitor checks each result
// transfer against the oldest prediction. Register phases cover local and
// remote mode and the temperature limit extremes.
// ---------------------------------------------------------------------------

module testbench;
  import rfpt_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 8;
  localparam int REPORT_MAX     = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  rfpt_item_t drv_tick = '0;

  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [LEVEL_W-1:0] pwm_value_o;
  logic power_led_n_o, overtemp_led_1_n_o, overtemp_led_2_n_o;
  logic fault_led_1_n_o, fault_led_2_n_o, remote_led_n_o;
  logic rf_on_o, enable_1_o, enable_2_o;

  rf_power_tick_controller u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .knob_a_i           (drv_tick.knob_a),
    .knob_b_i           (drv_tick.knob_b),
    .fault_in_1_i       (drv_tick.fault_in_1),
    .fault_in_2_i       (drv_tick.fault_in_2),
    .temp_sample_1_i    (drv_tick.temp_sample_1),
    .temp_sample_2_i    (drv_tick.temp_sample_2),
    .continuous_pin_i   (drv_tick.continuous_pin),
    .single_pin_i       (drv_tick.single_pin),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .pwm_value_o        (pwm_value_o),
    .power_led_n_o      (power_led_n_o),
    .overtemp_led_1_n_o (overtemp_led_1_n_o),
    .overtemp_led_2_n_o (overtemp_led_2_n_o),
    .fault_led_1_n_o    (fault_led_1_n_o),
    .fault_led_2_n_o    (fault_led_2_n_o),
    .remote_led_n_o     (remote_led_n_o),
    .rf_on_o            (rf_on_o),
    .enable_1_o         (enable_1_o),
    .enable_2_o         (enable_2_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  rfpt_item_t   tick_stim_q [$];
  rfpt_result_t tick_result_q [$];

  int  error_count = 0;
  int  results_seen = 0;
  int  idle_cycles = 0;
  int  send_gap = 0;
  int  hold_left = 0;
  bit  long_hold_done = 1'b0;
  bit  quiet_tail = 1'b0;

  // predictor copy of the registers and tick state, reset values
  logic               m_remote_mode = 1'b0;
  logic [LEVEL_W-1:0] m_remote_level = '0;
  logic               m_remote_pulse = 1'b0;
  logic               m_ch1_on = 1'b0;
  logic               m_ch2_on = 1'b0;
  logic [TEMP_W-1:0]  m_temp_limit = 10'd431;

  logic               m_prev_a = 1'b0;
  logic               m_prev_b = 1'b0;
  logic [KNOB_W-1:0]  m_knob = '0;
  logic [BLINK_W-1:0] m_blink = '0;
  logic [LEVEL_W-1:0] m_slew = '0;
  logic [HOLD_W-1:0]  m_hold_1 = '0;
  logic [HOLD_W-1:0]  m_hold_2 = '0;
  logic [SUM_W-1:0]   m_sum_1 = '0;
  logic [SUM_W-1:0]   m_sum_2 = '0;
  logic [AVG_W-1:0]   m_avg_cnt = '0;
  logic               m_hot_1 = 1'b0;
  logic               m_hot_2 = 1'b0;
  logic [6:0]         m_pulse = '0;

  // stimulus generator state
  int g_phase = 0;
  bit g_up = 1'b1;
  int g_run = 200;
  int g_count = 0;
  bit g_a = 1'b0;
  bit g_b = 1'b0;
  int g_lo_1 = 0, g_hi_1 = 1023, g_lo_2 = 0, g_hi_2 = 1023;

  // piecewise square root of the knob position
  function automatic int unsigned knob_to_level(logic [KNOB_W-1:0] pos);
    int unsigned slope, base;
    if (pos <= 16) begin
      slope = 372184; base = 0;
    end else if (pos <= 32) begin
      slope = 154164; base = 53;
    end else if (pos <= 48) begin
      slope = 118294; base = 71;
    end else if (pos <= 64) begin
      slope = 99726; base = 84;
    end else if (pos <= 80) begin
      slope = 87861; base = 96;
    end else if (pos <= 96) begin
      slope = 79432; base = 106;
    end else if (pos <= 112) begin
      slope = 73045; base = 116;
    end else begin
      slope = 68127; base = 124;
    end
    return (((int'(pos) * slope) >> 16) & 32'hFF) + base;
  endfunction

  task automatic compute_tick(input rfpt_item_t t, output rfpt_result_t r);
    int          pos, step;
    int unsigned lvl;
    logic        power_on, hold_1, hold_2, rf;
    if (!m_remote_mode) begin
      step = 0;
      // first matching edge wins: A rise, A fall, B rise, B fall
      if (t.knob_a && !m_prev_a) step = t.knob_b ? -1 : 1;
      else if (!t.knob_a && m_prev_a) step = t.knob_b ? 1 : -1;
      else if (t.knob_b && !m_prev_b) step = t.knob_a ? 1 : -1;
      else if (!t.knob_b && m_prev_b) step = t.knob_a ? -1 : 1;
      m_prev_a = t.knob_a;
      m_prev_b = t.knob_b;
      pos = int'(m_knob) + step;
      if (pos < 0) pos = 0;
      if (pos > KNOB_MAX_DEF) pos = KNOB_MAX_DEF;
      m_knob = KNOB_W'(pos);
      lvl = knob_to_level(m_knob);
    end else begin
      lvl = m_remote_level;
    end
    if (lvl > 256) lvl = 256;

    if (int'(m_blink) + 1 > BLINK_TOP_DEF) m_blink = '0;
    else m_blink = m_blink + 1'b1;
    power_on = int'(m_blink) < int'(lvl << 1);

    // forcing uses the holds from before this tick
    if (m_hold_1 != 0 || m_hold_2 != 0) lvl = 0;
    if (lvl < m_slew) m_slew = LEVEL_W'(lvl);
    else if (lvl >= int'(m_slew) + SLEW_STEP_DEF) m_slew = LEVEL_W'(int'(m_slew) + SLEW_STEP_DEF);
    else m_slew = LEVEL_W'(lvl);
    if (m_slew > 256) m_slew = 9'd256;

    m_sum_1 = m_sum_1 + SUM_W'(t.temp_sample_1);
    m_sum_2 = m_sum_2 + SUM_W'(t.temp_sample_2);
    m_avg_cnt = m_avg_cnt + 1'b1;
    if (m_avg_cnt == 0) begin
      m_hot_1 = (m_sum_1 >> 8) < m_temp_limit;
      m_hot_2 = (m_sum_2 >> 8) < m_temp_limit;
      m_sum_1 = '0;
      m_sum_2 = '0;
    end

    if (t.fault_in_1) m_hold_1 = HOLD_W'(FAULT_HOLD_DEF);
    else if (m_hold_1 != 0) m_hold_1 = m_hold_1 - 1'b1;
    if (t.fault_in_2) m_hold_2 = HOLD_W'(FAULT_HOLD_DEF);
    else if (m_hold_2 != 0) m_hold_2 = m_hold_2 - 1'b1;

    if (m_pulse < PULSE_PERIOD_DEF) m_pulse = m_pulse + 1'b1;
    else m_pulse = '0;

    hold_1 = m_hold_1 != 0;
    hold_2 = m_hold_2 != 0;
    if (m_remote_mode) begin
      rf = !m_remote_pulse || (m_pulse < PULSE_ON_DEF);
      r.enable_1 = !hold_1 && !m_hot_1 && m_ch1_on;
      r.enable_2 = !hold_2 && !m_hot_2 && m_ch2_on;
    end else begin
      rf = t.continuous_pin || (m_pulse < PULSE_ON_DEF);
      r.enable_1 = !hold_1 && !m_hot_1;
      r.enable_2 = !hold_2 && !m_hot_2 && !t.single_pin;
    end
    r.pwm_value        = 9'd256 - m_slew;
    r.power_led_n      = !power_on;
    r.overtemp_led_1_n = !m_hot_1;
    r.overtemp_led_2_n = !m_hot_2;
    r.fault_led_1_n    = !hold_1;
    r.fault_led_2_n    = !hold_2;
    r.remote_led_n     = !m_remote_mode;
    r.rf_on            = rf;
  endtask

  task automatic pick_band(output int lo, output int hi);
    case ($urandom_range(0, 3))
      0: begin lo = 0; hi = 1023; end
      1: begin lo = 0; hi = 400; end
      2: begin lo = 450; hi = 1023; end
      default: begin
        // straddle the limit so the average lands on either side
        lo = (int'(m_temp_limit) > 40) ? int'(m_temp_limit) - 40 : 0;
        hi = (int'(m_temp_limit) < 983) ? int'(m_temp_limit) + 40 : 1023;
      end
    endcase
  endtask

  // mostly clean quadrature steps with runs in one direction, some noise
  task automatic next_tick(output rfpt_item_t t);
    int r;
    if (g_count % 256 == 0) begin
      pick_band(g_lo_1, g_hi_1);
      pick_band(g_lo_2, g_hi_2);
    end
    r = $urandom_range(0, 99);
    if (r < 72) begin
      g_phase = (g_phase + (g_up ? 1 : 3)) % 4;
      g_a = (g_phase == 1) || (g_phase == 2);
      g_b = (g_phase >= 2);
      g_run = g_run - 1;
      if (g_run <= 0) begin
        g_up = !g_up;
        g_run = $urandom_range(20, 260);
      end
    end else if (r >= 88) begin
      g_a = $urandom_range(0, 1);
      g_b = $urandom_range(0, 1);
    end
    t.knob_a         = g_a;
    t.knob_b         = g_b;
    t.fault_in_1     = ($urandom_range(0, 699) == 0);
    t.fault_in_2     = ($urandom_range(0, 699) == 0);
    t.temp_sample_1  = TEMP_W'($urandom_range(g_lo_1, g_hi_1));
    t.temp_sample_2  = TEMP_W'($urandom_range(g_lo_2, g_hi_2));
    t.continuous_pin = $urandom_range(0, 1);
    t.single_pin     = $urandom_range(0, 1);
    g_count++;
  endtask

  task automatic queue_ticks(input int n);
    rfpt_item_t t;
    for (int i = 0; i < n; i++) begin
      next_tick(t);
      tick_stim_q.push_back(t);
    end
  endtask

  task automatic queue_directed(input bit a, input bit b, input bit f1, input bit f2,
                                input int t1, input int t2, input bit cont,
                                input bit single);
    rfpt_item_t t;
    t.knob_a = a; t.knob_b = b;
    t.fault_in_1 = f1; t.fault_in_2 = f2;
    t.temp_sample_1 = TEMP_W'(t1); t.temp_sample_2 = TEMP_W'(t2);
    t.continuous_pin = cont; t.single_pin = single;
    tick_stim_q.push_back(t);
  endtask

  // wait until all ticks are through and every result has come back
  task automatic drain();
    while (tick_stim_q.size() != 0 || in_valid_i || tick_result_q.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input rfpt_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_REMOTE_MODE:       m_remote_mode = data[0];
      REG_REMOTE_LEVEL:      m_remote_level = data[LEVEL_W-1:0];
      REG_REMOTE_PULSE_MODE: m_remote_pulse = data[0];
      REG_REMOTE_CH1_ON:     m_ch1_on = data[0];
      REG_REMOTE_CH2_ON:     m_ch2_on = data[0];
      REG_TEMP_LIMIT:        m_temp_limit = data[TEMP_W-1:0];
      default: ;
    endcase
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else begin
      rfpt_result_t r;
      if (in_valid_i && !in_stall_o) begin
        compute_tick(drv_tick, r);
        tick_result_q.push_back(r);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (tick_stim_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(0, 14);
          in_valid_i <= 1'b0;
        end else begin
          drv_tick <= tick_stim_q.pop_front();
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // receiver, with one long hold-off once results are flowing
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!long_hold_done && results_seen >= 200) begin
      long_hold_done <= 1'b1;
      hold_left <= 300;
      out_stall_i <= 1'b1;
    end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      hold_left <= $urandom_range(0, 14);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    rfpt_result_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {pwm_value_o, power_led_n_o, overtemp_led_1_n_o, overtemp_led_2_n_o,
             fault_led_1_n_o, fault_led_2_n_o, remote_led_n_o, rf_on_o,
             enable_1_o, enable_2_o};
      if (tick_result_q.size() == 0) begin
        if (error_count < REPORT_MAX)
          $display("result %0d: transfer with no tick pending, pwm_value %0d",
                   results_seen, got.pwm_value);
        error_count++;
      end else begin
        want = tick_result_q.pop_front();
        if (got !== want) begin
          if (error_count < REPORT_MAX)
            $display({"result %0d: pwm_value exp %0d got %0d | power_led_n %b/%b ",
                      "overtemp_n %b%b/%b%b fault_n %b%b/%b%b remote_n %b/%b ",
                      "rf_on %b/%b enable %b%b/%b%b (exp/got)"},
                     results_seen, want.pwm_value, got.pwm_value,
                     want.power_led_n, got.power_led_n,
                     want.overtemp_led_1_n, want.overtemp_led_2_n,
                     got.overtemp_led_1_n, got.overtemp_led_2_n,
                     want.fault_led_1_n, want.fault_led_2_n,
                     got.fault_led_1_n, got.fault_led_2_n,
                     want.remote_led_n, got.remote_led_n,
                     want.rf_on, got.rf_on,
                     want.enable_1, want.enable_2, got.enable_1, got.enable_2);
          error_count++;
        end
      end
      results_seen++;
    end
  end

  // watchdog: no transfer on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // knob edges, saturation at zero, both pins at once, field extremes
    queue_directed(0, 0, 0, 0, 0, 0, 0, 0);
    queue_directed(1, 1, 0, 0, 1023, 1023, 1, 1);
    queue_directed(0, 0, 0, 0, 0, 1023, 0, 1);
    queue_directed(1, 0, 0, 0, 1023, 0, 1, 0);
    queue_directed(1, 1, 0, 0, 0, 0, 0, 0);
    queue_directed(0, 1, 0, 0, 1023, 1023, 1, 1);
    queue_directed(0, 0, 0, 0, 0, 0, 0, 1);
    queue_directed(0, 1, 0, 0, 1023, 0, 1, 0);
    queue_directed(1, 1, 0, 0, 0, 1023, 0, 0);
    queue_directed(1, 0, 0, 0, 1023, 1023, 1, 1);
    queue_directed(0, 0, 0, 0, 0, 0, 0, 0);
    queue_directed(0, 1, 0, 0, 1023, 0, 1, 1);
    queue_directed(0, 0, 0, 0, 512, 511, 0, 0);
    queue_directed(1, 0, 0, 0, 341, 682, 1, 0);
    queue_directed(1, 1, 0, 0, 682, 341, 0, 1);
    queue_directed(0, 1, 0, 0, 1023, 1023, 1, 0);
    queue_directed(0, 0, 0, 0, 0, 0, 0, 1);
    queue_directed(1, 0, 0, 0, 1023, 0, 1, 1);
    queue_directed(1, 1, 1, 0, 0, 1023, 0, 0);
    queue_directed(1, 1, 0, 0, 1023, 1023, 1, 0);
    queue_directed(1, 1, 0, 1, 0, 0, 0, 1);
    queue_directed(1, 1, 1, 1, 1023, 0, 1, 1);
    queue_directed(1, 1, 0, 0, 0, 1023, 0, 0);

    queue_ticks(500);
    drain();

    // remote mode, level written far above the cap, limit at zero
    write_reg(REG_REMOTE_MODE, 10'd1);
    write_reg(REG_REMOTE_LEVEL, 10'h3FF);
    write_reg(REG_REMOTE_PULSE_MODE, 10'd1);
    write_reg(REG_REMOTE_CH1_ON, 10'd1);
    write_reg(REG_REMOTE_CH2_ON, 10'd0);
    write_reg(REG_TEMP_LIMIT, 10'd0);
    queue_ticks(250);
    drain();

    write_reg(REG_REMOTE_LEVEL, 10'd0);
    write_reg(REG_REMOTE_PULSE_MODE, 10'd0);
    write_reg(REG_REMOTE_CH1_ON, 10'd0);
    write_reg(REG_REMOTE_CH2_ON, 10'd1);
    write_reg(REG_TEMP_LIMIT, 10'd1023);
    queue_ticks(150);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_reg(REG_REMOTE_LEVEL, CFG_DATA_W'($urandom_range(0, 1023)));
      write_reg(REG_REMOTE_PULSE_MODE, CFG_DATA_W'($urandom_range(0, 1023)));
      write_reg(REG_REMOTE_CH1_ON, CFG_DATA_W'($urandom_range(0, 1023)));
      write_reg(REG_REMOTE_CH2_ON, CFG_DATA_W'($urandom_range(0, 1023)));
      write_reg(REG_TEMP_LIMIT, CFG_DATA_W'($urandom_range(0, 1023)));
      queue_ticks(60);
      drain();
    end

    write_reg(REG_REMOTE_MODE, 10'd0);
    write_reg(REG_TEMP_LIMIT, 10'd431);
    queue_ticks(300);
    while (tick_stim_q.size() != 0) @(posedge clk_i);

    // last stretch runs at full rate on both sides
    quiet_tail <= 1'b1;
    queue_ticks(100);
    drain();

    if (error_count == 0 && tick_result_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
